[design/dsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and segment table for the decimal seven-segment driver
// no dependencies

package dsd_pkg;

    localparam int unsigned ValueW   = 16;
    localparam int unsigned SatW     = 14;
    localparam int unsigned DigitW   = 4;
    localparam int unsigned NumDigits = 4;
    localparam int unsigned BitsPerDigit = 16;
    localparam int unsigned FrameW   = NumDigits * BitsPerDigit;
    localparam int unsigned CntW     = $clog2(FrameW);

    localparam logic [SatW-1:0] MaxShown = 14'd9999;

    // reciprocal constants, exact for the ranges used here
    localparam logic [SatW-1:0] RecipThou = 14'd8389;  // >> 23
    localparam int unsigned     ShThou    = 23;
    localparam logic [5:0]      RecipHund = 6'd41;     // >> 12
    localparam int unsigned     ShHund    = 12;
    localparam logic [6:0]      RecipTen  = 7'd103;    // >> 10
    localparam int unsigned     ShTen     = 10;

    localparam logic [SatW-1:0] Thou = 14'd1000;
    localparam logic [9:0]      Hund = 10'd100;
    localparam logic [6:0]      Ten  = 7'd10;

    typedef struct packed {
        logic [DigitW-1:0] thou;
        logic [DigitW-1:0] hund;
        logic [DigitW-1:0] tens;
        logic [DigitW-1:0] units;
    } t_digits;

    // active-low common-anode codes, bit7 dp .. bit0 a
    function automatic logic [7:0] seg_code(input logic [DigitW-1:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'hC0;
            4'd1:    c = 8'hF9;
            4'd2:    c = 8'hA4;
            4'd3:    c = 8'hB0;
            4'd4:    c = 8'h99;
            4'd5:    c = 8'h92;
            4'd6:    c = 8'h82;
            4'd7:    c = 8'hF8;
            4'd8:    c = 8'h80;
            4'd9:    c = 8'h90;
            default: c = 8'hFF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/decimal_seven_segment_serial_driver_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// a value passes the six digit stages and the frame register before its first bit
// throughput: 64 transfers per value, one shifted bit per cycle while tready is high
// during a frame the six-stage digit pipeline runs until its last stage holds one
// reset: synchronous active-low i_rst_n clears all valid bits and the bit counter
// depends on dsd_pkg, dsd_digit_split, dsd_serializer

module decimal_seven_segment_serial_driver_top
    import dsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] serial_bit, [7:1] zero
    output logic             m_axis_tuser,   // [0] latch_pulse
    output logic             m_axis_tlast    // last_bit
);

    logic    w_split_vld;
    t_digits w_digits;
    logic    w_ser_rdy;
    logic    w_en;
    logic    w_bit;

    assign w_en          = !w_split_vld || w_ser_rdy;
    assign s_axis_tready = w_en;

    dsd_digit_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_value  (s_axis_tdata),
        .o_valid  (w_split_vld),
        .o_digits (w_digits)
    );

    dsd_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_split_vld),
        .i_digits    (w_digits),
        .o_ready     (w_ser_rdy),
        .o_bit       (w_bit),
        .o_latch     (m_axis_tuser),
        .o_last      (m_axis_tlast),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, w_bit};

endmodule

`default_nettype wire

[design/dsd_digit_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// six-stage pipeline that saturates a value and splits it into four decimal digits
// depends on dsd_pkg

module dsd_digit_split
    import dsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [ValueW-1:0] i_value,
    output logic                   o_valid,
    output t_digits                o_digits
);

    localparam int unsigned Stages = 6;

    logic [Stages-1:0] r_vld;

    // stage 1: saturate and multiply by reciprocal of 1000
    logic [SatW-1:0]   n_sat;
    logic [SatW-1:0]   r_v1;
    logic [2*SatW-1:0] r_p1;
    // stage 2: thousands and remainder
    logic [DigitW-1:0] r_q1_2;
    logic [9:0]        r_r1;
    logic [DigitW-1:0] n_q1;
    logic [SatW-1:0]   n_r1;
    // stage 3: multiply by reciprocal of 100
    logic [DigitW-1:0] r_q1_3;
    logic [9:0]        r_r1_3;
    logic [15:0]       r_p2;
    // stage 4: hundreds and remainder
    logic [DigitW-1:0] r_q1_4, r_q2_4;
    logic [6:0]        r_r2;
    logic [DigitW-1:0] n_q2;
    logic [9:0]        n_r2;
    // stage 5: multiply by reciprocal of 10
    logic [DigitW-1:0] r_q1_5, r_q2_5;
    logic [6:0]        r_r2_5;
    logic [13:0]       r_p3;
    // stage 6: tens and units
    t_digits           r_dig;
    logic [DigitW-1:0] n_q3;
    logic [6:0]        n_u;

    always_comb begin
        n_sat = (i_value > ValueW'(MaxShown)) ? MaxShown : i_value[SatW-1:0];
        n_q1  = r_p1[ShThou +: DigitW];
        n_r1  = r_v1 - SatW'(n_q1) * Thou;
        n_q2  = r_p2[ShHund +: DigitW];
        n_r2  = r_r1_3 - 10'(n_q2) * Hund;
        n_q3  = r_p3[ShTen +: DigitW];
        n_u   = r_r2_5 - 7'(n_q3) * Ten;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1      <= n_sat;
            r_p1      <= (2*SatW)'(n_sat) * (2*SatW)'(RecipThou);
            r_q1_2    <= n_q1;
            r_r1      <= n_r1[9:0];
            r_q1_3    <= r_q1_2;
            r_r1_3    <= r_r1;
            r_p2      <= 16'(r_r1) * 16'(RecipHund);
            r_q1_4    <= r_q1_3;
            r_q2_4    <= n_q2;
            r_r2      <= n_r2[6:0];
            r_q1_5    <= r_q1_4;
            r_q2_5    <= r_q2_4;
            r_r2_5    <= r_r2;
            r_p3      <= 14'(r_r2) * 14'(RecipTen);
            r_dig.thou  <= r_q1_5;
            r_dig.hund  <= r_q2_5;
            r_dig.tens  <= n_q3;
            r_dig.units <= n_u[DigitW-1:0];
        end
    end

    assign o_valid  = r_vld[Stages-1];
    assign o_digits = r_dig;

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digits.thou <= 4'd9 && o_digits.hund <= 4'd9
                     && o_digits.tens <= 4'd9 && o_digits.units <= 4'd9))
        else $error("digit out of decimal range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r_r1 < 10'd1000)
        else $error("thousands remainder out of range");

endmodule

`default_nettype wire

[design/dsd_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none
// builds the 64-bit digit frame and shifts it out one bit per transfer
// depends on dsd_pkg

module dsd_serializer
    import dsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_digits i_digits,
    output logic         o_ready,
    output logic         o_bit,
    output logic         o_latch,
    output logic         o_last,
    output logic         o_valid,
    input  wire logic    i_out_ready
);

    logic              r_busy;
    logic [CntW-1:0]   r_cnt;
    logic [FrameW-1:0] r_shift;
    logic [FrameW-1:0] n_frame;
    logic              w_xfer;
    logic              w_end;

    always_comb begin
        n_frame = {seg_code(i_digits.thou),  8'h08,
                   seg_code(i_digits.hund),  8'h04,
                   seg_code(i_digits.tens),  8'h02,
                   seg_code(i_digits.units), 8'h01};
    end

    assign w_xfer  = r_busy && i_out_ready;
    assign w_end   = (r_cnt == CntW'(FrameW - 1));
    assign o_ready = !r_busy || (w_xfer && w_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_cnt  <= '0;
        end else if (w_xfer) begin
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_shift <= n_frame;
        end else if (w_xfer) begin
            r_shift <= {r_shift[FrameW-2:0], 1'b0};
        end
    end

    assign o_valid = r_busy;
    assign o_bit   = r_shift[FrameW-1];
    assign o_latch = &r_cnt[3:0];
    assign o_last  = w_end;

    a_last_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_latch)
        else $error("frame end without latch pulse");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !w_end |=> r_busy && r_cnt == $past(r_cnt) + 1'b1)
        else $error("bit counter skipped");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && w_end && !i_valid |=> !r_busy)
        else $error("serializer stayed busy after frame");

endmodule

`default_nettype wire
